// ===== hdl/ring_buffer_deque_macros.svh =====
// Assertion macros shared by the ring buffer deque RTL.
`ifndef RING_BUFFER_DEQUE_MACROS_SVH
`define RING_BUFFER_DEQUE_MACROS_SVH

// Same-cycle implication, disabled while reset is low.
`define RBD_ASSERT_NOW(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled while reset is low.
`define RBD_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== hdl/rbd_pkg.sv =====
// Package for the ring buffer deque: widths, codes and state type.
package rbd_pkg;

  localparam int RBD_DEPTH = 16;
  localparam int DATA_W    = 32;
  localparam int CMD_W     = 2;
  localparam int STAT_W    = 2;
  localparam int OCC_W     = 5;

  localparam logic [CMD_W-1:0] CMD_PUSH_TAIL = 2'd0;
  localparam logic [CMD_W-1:0] CMD_PUSH_HEAD = 2'd1;
  localparam logic [CMD_W-1:0] CMD_POP       = 2'd2;

  localparam logic [STAT_W-1:0] STAT_DONE  = 2'd0;
  localparam logic [STAT_W-1:0] STAT_FULL  = 2'd1;
  localparam logic [STAT_W-1:0] STAT_EMPTY = 2'd2;

  localparam logic signed [DATA_W-1:0] EMPTY_POP_VALUE = {DATA_W{1'b1}};

  typedef enum logic {
    S_IDLE,
    S_POP
  } rbd_state_t;

endpackage

// ===== hdl/rbd_if.sv =====
// Handshake interfaces for the deque command and result channels.
interface rbd_cmd_if
  import rbd_pkg::*;
();
  logic                     valid;
  logic                     ready;
  logic [CMD_W-1:0]         cmd;
  logic signed [DATA_W-1:0] push_value;

  modport source (output valid, output cmd, output push_value, input ready);
  modport sink   (input valid, input cmd, input push_value, output ready);
endinterface

interface rbd_res_if
  import rbd_pkg::*;
();
  logic                     valid;
  logic                     ready;
  logic signed [DATA_W-1:0] pop_value;
  logic [STAT_W-1:0]        status;
  logic                     is_full;
  logic                     is_empty;
  logic [OCC_W-1:0]         occupancy;

  modport source (output valid, output pop_value, output status, output is_full,
                  output is_empty, output occupancy, input ready);
  modport sink   (input valid, input pop_value, input status, input is_full,
                  input is_empty, input occupancy, output ready);
endinterface

// ===== hdl/rbd_slot_ram.sv =====
// Slot storage: one write port, one read port with registered read data.
module rbd_slot_ram
  import rbd_pkg::*;
#(
  parameter int DEPTH  = RBD_DEPTH,
  parameter int ADDR_W = $clog2(RBD_DEPTH)
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [ADDR_W-1:0]        wr_addr,
  input  logic signed [DATA_W-1:0] wr_data,
  input  logic                     rd_en,
  input  logic [ADDR_W-1:0]        rd_addr,
  output logic signed [DATA_W-1:0] rd_data
);

  logic signed [DATA_W-1:0] mem [DEPTH];
  logic signed [DATA_W-1:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

// ===== hdl/ring_buffer_deque.sv =====
// Top level of the ring buffer deque: pointers, occupancy and result register.
// A circular deque of DEPTH signed 32-bit words held in a one-port-read,
// one-port-write slot memory with registered read data. Pushes at tail or
// head and rejected commands finish in S_IDLE; a pop that finds data goes on
// to S_POP, where the slot memory read data is loaded as the result. Every
// command yields one result item, held in an output register; a new command
// is taken in S_IDLE once that register is free or being emptied in the same
// cycle. Slots need no clearing after reset: the block is ready once rst_n rises.
module ring_buffer_deque
  import rbd_pkg::*;
#(
  parameter int DEPTH = RBD_DEPTH
) (
  input  logic  clk,
  input  logic  rst_n,
  rbd_cmd_if.sink   in_if,
  rbd_res_if.source out_if
);

`include "ring_buffer_deque_macros.svh"

  localparam int PTR_W = $clog2(DEPTH);
  localparam int CNT_W = $clog2(DEPTH + 1);

  localparam logic [PTR_W-1:0] PTR_LAST  = PTR_W'(DEPTH - 1);
  localparam logic [CNT_W-1:0] CNT_DEPTH = CNT_W'(DEPTH);

  rbd_state_t state_r, state_nxt;
  logic [PTR_W-1:0] head_r, head_nxt;
  logic [PTR_W-1:0] tail_r, tail_nxt;
  logic [CNT_W-1:0] count_r, count_nxt;

  logic                     out_valid_r, out_valid_nxt;
  logic signed [DATA_W-1:0] out_pop_value_r;
  logic [STAT_W-1:0]        out_status_r;
  logic                     out_is_full_r;
  logic                     out_is_empty_r;
  logic [OCC_W-1:0]         out_occupancy_r;

  logic                     in_ready;
  logic                     accept;
  logic                     buf_full;
  logic                     buf_empty;
  logic                     res_load;
  logic signed [DATA_W-1:0] res_pop_value;
  logic [STAT_W-1:0]        res_status;
  logic [OCC_W+CNT_W-1:0]   occ_ext;

  logic                     wr_en;
  logic [PTR_W-1:0]         wr_addr;
  logic                     rd_en;
  logic signed [DATA_W-1:0] rd_data;

  rbd_slot_ram #(
    .DEPTH  (DEPTH),
    .ADDR_W (PTR_W)
  ) u_slot_ram (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (in_if.push_value),
    .rd_en   (rd_en),
    .rd_addr (head_r),
    .rd_data (rd_data)
  );

  assign in_ready    = (state_r == S_IDLE) && (!out_valid_r || out_if.ready);
  assign accept      = in_if.valid && in_ready;
  assign in_if.ready = in_ready;
  assign buf_full    = (count_r == CNT_DEPTH);
  assign buf_empty   = (count_r == '0);

  always_comb begin
    state_nxt     = state_r;
    head_nxt      = head_r;
    tail_nxt      = tail_r;
    count_nxt     = count_r;
    wr_en         = 1'b0;
    wr_addr       = tail_r;
    rd_en         = 1'b0;
    res_load      = 1'b0;
    res_pop_value = '0;
    res_status    = STAT_DONE;

    unique case (state_r)
      S_IDLE: begin
        if (accept) begin
          res_load = 1'b1;
          unique case (in_if.cmd)
            CMD_PUSH_TAIL: begin
              if (buf_full) begin
                res_status = STAT_FULL;
              end else begin
                tail_nxt  = (tail_r == PTR_LAST) ? '0 : tail_r + 1'b1;
                wr_en     = 1'b1;
                wr_addr   = tail_nxt;
                count_nxt = count_r + 1'b1;
              end
            end
            CMD_PUSH_HEAD: begin
              if (buf_full) begin
                res_status = STAT_FULL;
              end else begin
                head_nxt  = (head_r == '0) ? PTR_LAST : head_r - 1'b1;
                wr_en     = 1'b1;
                wr_addr   = head_nxt;
                count_nxt = count_r + 1'b1;
              end
            end
            CMD_POP: begin
              if (buf_empty) begin
                res_status    = STAT_EMPTY;
                res_pop_value = EMPTY_POP_VALUE;
              end else begin
                res_load  = 1'b0;
                rd_en     = 1'b1;
                head_nxt  = (head_r == PTR_LAST) ? '0 : head_r + 1'b1;
                count_nxt = count_r - 1'b1;
                state_nxt = S_POP;
              end
            end
            default: begin
            end
          endcase
        end
      end
      S_POP: begin
        res_load      = 1'b1;
        res_pop_value = rd_data;
        state_nxt     = S_IDLE;
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase

    if (res_load) begin
      out_valid_nxt = 1'b1;
    end else if (out_if.ready) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  assign occ_ext = {{OCC_W{1'b0}}, count_nxt};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      head_r      <= '0;
      tail_r      <= PTR_LAST;
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      head_r      <= head_nxt;
      tail_r      <= tail_nxt;
      count_r     <= count_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (res_load) begin
      out_pop_value_r <= res_pop_value;
      out_status_r    <= res_status;
      out_is_full_r   <= (count_nxt == CNT_DEPTH);
      out_is_empty_r  <= (count_nxt == '0);
      out_occupancy_r <= occ_ext[OCC_W-1:0];
    end
  end

  assign out_if.valid     = out_valid_r;
  assign out_if.pop_value = out_pop_value_r;
  assign out_if.status    = out_status_r;
  assign out_if.is_full   = out_is_full_r;
  assign out_if.is_empty  = out_is_empty_r;
  assign out_if.occupancy = out_occupancy_r;

  `RBD_ASSERT_NOW(a_count_bound, clk, rst_n, 1'b1, count_r <= CNT_DEPTH, "count above depth")
  `RBD_ASSERT_NOW(a_no_take_in_pop, clk, rst_n, state_r == S_POP, !in_if.ready, "ready during pop read")
  `RBD_ASSERT_NEXT(a_pop_reads, clk, rst_n, accept && in_if.cmd == CMD_POP && !buf_empty, state_r == S_POP && out_valid_r == 1'b0, "pop did not start read")
  `RBD_ASSERT_NEXT(a_full_push_holds, clk, rst_n, accept && in_if.cmd != CMD_POP && buf_full, $stable(count_r) && $stable(head_r) && $stable(tail_r), "rejected push moved state")
  `RBD_ASSERT_NOW(a_flags_excl, clk, rst_n, out_valid_r, !(out_is_full_r && out_is_empty_r), "full and empty together")

endmodule
